// ===== src/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants of the key matrix debouncer
// Field widths, queue depths, reset values and the command encoding that
// travels from the classifying front end to the state-holding back end.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

	// Fixed field widths of the ports.
	localparam int COL_W      = 11;
	localparam int ROW_IN_W   = 2;
	localparam int CNT_W      = 8;

	// Widest row the parameters allow.
	localparam int MAX_COLS   = 32;

	// Parameter defaults.
	localparam int ROWS_DEFAULT = 4;
	localparam int COLS_DEFAULT = 11;

	// Quiet counter and debounce register after reset.
	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

	// Queue depths.
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	// Result beat: row_bits, settled, counter_left.
	localparam int RES_W = COL_W + 1 + CNT_W;

	typedef enum logic [1:0] {
		KIND_READ     = 2'd0,
		KIND_SAMPLE   = 2'd1,
		KIND_SCAN_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  row_ok;
	} cmd_ctl_t;

	localparam int CTL_W = $bits(cmd_ctl_t);

endpackage

`default_nettype wire

// ===== src/kmd_fifo.sv =====
// ----------------------------------------------------------------------------
// kmd_fifo: small flip-flop queue
// First-in first-out buffer with full and empty flags; a push and a pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/kmd_front.sv =====
// ----------------------------------------------------------------------------
// kmd_front: input classifier
// Sorts each accepted beat into read, plain sample or scan-end sample, checks
// the row against the matrix size and trims the column bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_front #(
	parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
	parameter int COLS = kmd_pkg::COLS_DEFAULT,
	localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         action,
	input  wire logic [kmd_pkg::ROW_IN_W-1:0] row_index,
	input  wire logic [kmd_pkg::COL_W-1:0]    column_bits,
	input  wire logic                         scan_end,
	input  wire logic                         q_full,
	output logic                              q_push,
	output kmd_pkg::cmd_ctl_t                 cmd_ctl,
	output logic      [RowIdxW-1:0]           cmd_idx,
	output logic      [COLS-1:0]              cmd_cols
);

	logic [kmd_pkg::MAX_COLS-1:0] col_ext;

	assign full    = q_full;
	assign q_push  = push && !q_full;
	assign col_ext = kmd_pkg::MAX_COLS'(column_bits);

	always_comb begin
		if (action) begin
			cmd_ctl.kind = kmd_pkg::KIND_READ;
		end else if (scan_end) begin
			cmd_ctl.kind = kmd_pkg::KIND_SCAN_END;
		end else begin
			cmd_ctl.kind = kmd_pkg::KIND_SAMPLE;
		end
		cmd_ctl.row_ok = (int'(row_index) < ROWS);
		cmd_idx        = RowIdxW'(row_index);
		cmd_cols       = col_ext[COLS-1:0];
	end

endmodule

`default_nettype wire

// ===== src/kmd_back.sv =====
// ----------------------------------------------------------------------------
// kmd_back: debounce state and result generation
// Holds the pending and stable rows, the shared quiet counter and the debounce
// register; executes one command per cycle unless a full result queue stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_back #(
	parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
	parameter int COLS = kmd_pkg::COLS_DEFAULT,
	localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [kmd_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic                        cmd_valid,
	input  wire kmd_pkg::cmd_ctl_t           cmd_ctl,
	input  wire logic [RowIdxW-1:0]          cmd_idx,
	input  wire logic [COLS-1:0]             cmd_cols,
	output logic                             cmd_pop,
	input  wire logic                        res_full,
	output logic                             res_push,
	output logic      [kmd_pkg::COL_W-1:0]   res_row_bits,
	output logic                             res_settled,
	output logic      [kmd_pkg::CNT_W-1:0]   res_counter_left
);

	logic [COLS-1:0]             stable_q  [ROWS];
	logic [COLS-1:0]             pending_q [ROWS];
	logic [COLS-1:0]             pend_nx   [ROWS];
	logic [kmd_pkg::CNT_W-1:0]   counter_q;
	logic [kmd_pkg::CNT_W-1:0]   debounce_q;
	logic [kmd_pkg::CNT_W-1:0]   cnt_load;
	logic [kmd_pkg::CNT_W-1:0]   cnt_nx;
	logic                        settle;
	logic [COLS-1:0]             rd_bits;
	logic [kmd_pkg::MAX_COLS-1:0] rd_ext;
	logic                        needs_res;

	assign needs_res = (cmd_ctl.kind != kmd_pkg::KIND_SAMPLE);
	assign cmd_pop   = cmd_valid && (!needs_res || !res_full);
	assign res_push  = cmd_pop && needs_res;

	// Sample update and scan-end countdown.
	always_comb begin
		pend_nx  = pending_q;
		cnt_load = counter_q;
		settle   = 1'b0;
		if (cmd_ctl.row_ok && (pending_q[cmd_idx] != cmd_cols)) begin
			pend_nx[cmd_idx] = cmd_cols;
			cnt_load         = debounce_q;
		end
		cnt_nx = cnt_load;
		if (cnt_load != '0) begin
			cnt_nx = cnt_load - 1'b1;
			settle = (cnt_nx == '0);
		end
	end

	assign rd_bits = cmd_ctl.row_ok ? stable_q[cmd_idx] : '0;
	assign rd_ext  = kmd_pkg::MAX_COLS'(rd_bits);

	always_comb begin
		res_row_bits     = '0;
		res_settled      = 1'b0;
		res_counter_left = '0;
		unique case (cmd_ctl.kind)
			kmd_pkg::KIND_READ: begin
				res_row_bits = rd_ext[kmd_pkg::COL_W-1:0];
			end
			kmd_pkg::KIND_SCAN_END: begin
				res_settled      = settle;
				res_counter_left = cnt_nx;
			end
			default: begin
				res_row_bits = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				stable_q[r]  <= '0;
				pending_q[r] <= '0;
			end
			counter_q  <= kmd_pkg::DEBOUNCE_RESET;
			debounce_q <= kmd_pkg::DEBOUNCE_RESET;
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_data;
			end
			if (cmd_pop && (cmd_ctl.kind != kmd_pkg::KIND_READ)) begin
				pending_q <= pend_nx;
				if (cmd_ctl.kind == kmd_pkg::KIND_SCAN_END) begin
					counter_q <= cnt_nx;
					if (settle) begin
						stable_q <= pend_nx;
					end
				end else begin
					counter_q <= cnt_load;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/key_matrix_debouncer.sv =====
// ----------------------------------------------------------------------------
// key_matrix_debouncer: key matrix debouncer with one shared quiet counter
// Takes sampled matrix rows and read requests, keeps a pending and a stable
// copy of every row, and settles all rows together after enough quiet scans.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake             | Beat contents
// ----------+-----------------------+------------------------------------------
// input     | push / full           | action, row_index, column_bits, scan_end
// result    | empty / pop           | row_bits, settled, counter_left
// config    | cfg_valid / cfg_ready | cfg_debounce_scans
//
// One input beat is taken per cycle while full is low. A beat enters the
// two-entry command queue when it is accepted and is executed by the back
// end once it reaches the head of the queue and the back end does not stall;
// its result, if any, then enters the result queue, shown at the result ports.
// The back end stalls only on a read or scan-end beat while the two-entry
// result queue is full; plain samples never wait for the result side.
// Full rises once the command queue holds two beats, which only happens while
// the back end is stalled.
// Reset clears every pending and stable row and loads the counter and the
// debounce register with five; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debouncer #(
	parameter int ROWS = kmd_pkg::ROWS_DEFAULT,
	parameter int COLS = kmd_pkg::COLS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Input queue side.
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         action,
	input  wire logic [kmd_pkg::ROW_IN_W-1:0] row_index,
	input  wire logic [kmd_pkg::COL_W-1:0]    column_bits,
	input  wire logic                         scan_end,
	// Result queue side.
	output logic                              empty,
	input  wire logic                         pop,
	output logic      [kmd_pkg::COL_W-1:0]    row_bits,
	output logic                              settled,
	output logic      [kmd_pkg::CNT_W-1:0]    counter_left,
	// Configuration write channel.
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [kmd_pkg::CNT_W-1:0]    cfg_debounce_scans
);

	localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CmdW    = kmd_pkg::CTL_W + RowIdxW + COLS;

	// Front end outputs headed for the command queue.
	logic                  q_push;
	logic                  q_full;
	kmd_pkg::cmd_ctl_t     f_ctl;
	logic [RowIdxW-1:0]    f_idx;
	logic [COLS-1:0]       f_cols;

	// Command queue head as seen by the back end.
	logic [CmdW-1:0]       q_rdata;
	logic                  q_empty;
	logic                  q_pop;
	kmd_pkg::cmd_ctl_t     b_ctl;
	logic [RowIdxW-1:0]    b_idx;
	logic [COLS-1:0]       b_cols;

	// Back end result beat headed for the result queue.
	logic                  r_push;
	logic                  r_full;
	logic [kmd_pkg::COL_W-1:0] r_row_bits;
	logic                  r_settled;
	logic [kmd_pkg::CNT_W-1:0] r_counter_left;
	logic [kmd_pkg::RES_W-1:0] r_rdata;

	// The register can be written at any time; the user only writes it idle.
	assign cfg_ready = 1'b1;

	kmd_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.push        (push),
		.full        (full),
		.action      (action),
		.row_index   (row_index),
		.column_bits (column_bits),
		.scan_end    (scan_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.cmd_ctl     (f_ctl),
		.cmd_idx     (f_idx),
		.cmd_cols    (f_cols)
	);

	kmd_fifo #(
		.WIDTH(CmdW),
		.DEPTH(kmd_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_ctl, f_idx, f_cols}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_ctl, b_idx, b_cols} = q_rdata;

	kmd_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_debounce_scans),
		.cmd_valid        (!q_empty),
		.cmd_ctl          (b_ctl),
		.cmd_idx          (b_idx),
		.cmd_cols         (b_cols),
		.cmd_pop          (q_pop),
		.res_full         (r_full),
		.res_push         (r_push),
		.res_row_bits     (r_row_bits),
		.res_settled      (r_settled),
		.res_counter_left (r_counter_left)
	);

	// The result queue doubles as the output register; waiting results hold up
	// read and scan-end beats once the queue is full, which can back up input.
	kmd_fifo #(
		.WIDTH(kmd_pkg::RES_W),
		.DEPTH(kmd_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  ({r_row_bits, r_settled, r_counter_left}),
		.full   (r_full),
		.pop    (pop),
		.rdata  (r_rdata),
		.empty  (empty)
	);

	assign {row_bits, settled, counter_left} = r_rdata;

endmodule

`default_nettype wire

// ===== src/kmd_checker.sv =====
// ----------------------------------------------------------------------------
// kmd_checker: port-level checks of the key matrix debouncer
// Watches the result port, checks the shape of every result beat and checks that a waiting result stays put.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      empty,
	input wire logic                      pop,
	input wire logic [kmd_pkg::COL_W-1:0] row_bits,
	input wire logic                      settled,
	input wire logic [kmd_pkg::CNT_W-1:0] counter_left
);

	// A beat is either a read (no counter fields) or a scan end (no row bits).
	a_beat_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((row_bits == '0) || (!settled && (counter_left == '0))))
		else $error("result beat mixes read and scan-end fields");

	// Settling happens only when the counter has just run out.
	a_settle_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && settled) |-> (counter_left == '0))
		else $error("settled reported with counter still running");

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(row_bits) && $stable(settled)
			&& $stable(counter_left)))
		else $error("waiting result changed or vanished");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.row_bits     (row_bits),
	.settled      (settled),
	.counter_left (counter_left)
);

`default_nettype wire
